### design/isoc_pkg.sv
// Shared constants, codes and types of the interval set operation block.
package isoc_pkg;

  localparam int AddrBits  = 32;
  localparam int CountBits = 16;
  localparam int LoBits    = AddrBits + 1;           // range cursor, one bit of headroom
  localparam int KBits     = $clog2(AddrBits + 1);   // block size exponent 0..AddrBits
  localparam int LenBits   = 6;

  // marker kinds
  localparam logic [1:0] KIND_A_OPEN  = 2'd0;
  localparam logic [1:0] KIND_A_CLOSE = 2'd1;
  localparam logic [1:0] KIND_B_OPEN  = 2'd2;
  localparam logic [1:0] KIND_B_CLOSE = 2'd3;

  // set operations; the spare code behaves as difference
  localparam logic [1:0] OP_UNION = 2'd0;
  localparam logic [1:0] OP_INTER = 2'd1;
  localparam logic [1:0] OP_DIFF  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RISE,
    ST_FALL
  } state_e;

  // x_nz / y_nz: nesting count of the own / other set is nonzero
  function automatic logic op_holds(logic [1:0] op, logic x_nz, logic y_nz);
    logic r;
    case (op)
      OP_UNION: r = x_nz | y_nz;
      OP_INTER: r = x_nz & y_nz;
      default:  r = ~x_nz & y_nz;
    endcase
    return r;
  endfunction

endpackage

### design/interval_set_op_to_cidr_top.sv
// Interval sweep set operation with range-to-prefix splitting, top level.
//
// Usage: markers arrive on the in_* channel (valid/ready) in ascending address
// order; group_end_i flags the last marker of a run of equal addresses. The
// configured operation (set_operation_i on the cfg_* channel: union,
// intersection, two-sided difference) is evaluated at each group end. When a
// result range closes it is split into the fewest aligned prefixes, one per
// request on the out_* channel, the final one marked with last_of_run_o.
// Timing: a marker that closes a nonempty range occupies the block while one
// shared add/compare unit walks the block size exponent up from 0 to at most
// 32 and back down, at most to 0, one step per cycle while the receiver does
// not stall; in_ready_o is low during the walk. Any other marker is taken
// every cycle unless a configuration write is offered.
// The prefix found in a step goes into an output register, so the walk keeps
// going while the receiver takes the previous request; if the receiver
// stalls with the register full, the walk halts and the request holds.
// Reset clears counts, inside flags, the operation (union) and output valid.
// Configuration is accepted only while no range is being split, wins over a
// marker offered in the same cycle, and drops any result range still open.
module interval_set_op_to_cidr_top import isoc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // marker requests
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [AddrBits-1:0] marker_address_i,
  input  logic [1:0]          marker_kind_i,
  input  logic                group_end_i,
  // prefix requests
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [AddrBits-1:0] prefix_address_o,
  output logic [LenBits-1:0]  prefix_length_o,
  output logic                result_side_o,
  output logic                last_of_run_o,
  // configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          set_operation_i
);

  // sweep state
  state_e                 state_q, state_d;
  logic [1:0]             set_op_q, set_op_d;
  logic [CountBits-1:0]   count_a_q, count_a_d;
  logic [CountBits-1:0]   count_b_q, count_b_d;
  logic                   inside_first_q, inside_first_d;
  logic                   inside_second_q, inside_second_d;
  logic [AddrBits-1:0]    start_first_q, start_first_d;
  logic [AddrBits-1:0]    start_second_q, start_second_d;

  // splitter: cursor lo, inclusive end hi, current block span 2^k-1
  logic [LoBits-1:0]      lo_q, lo_d;
  logic [AddrBits-1:0]    hi_q, hi_d;
  logic [LoBits-1:0]      span_q, span_d;
  logic [KBits-1:0]       k_q, k_d;
  logic                   side_q, side_d;

  // output register
  logic                   out_valid_q;
  logic [AddrBits-1:0]    out_addr_q;
  logic [LenBits-1:0]     out_len_q;
  logic                   out_side_q;
  logic                   out_last_q;

  logic                   in_fire, cfg_fire, out_free, emit, emit_last;
  logic                   is_open, track_second;
  logic                   holds_first, holds_second;
  logic [CountBits-1:0]   ca_n, cb_n;
  logic [AddrBits-1:0]    addr_next;
  logic                   close_first, close_second;
  logic [AddrBits-1:0]    close_lo, close_hi;
  logic                   close_empty;
  logic [LoBits-1:0]      sum;
  logic                   fit, at_end, bit_set;

  localparam logic [AddrBits-1:0]  AddrMax  = '1;
  localparam logic [CountBits-1:0] CountMax = '1;

  // a pending operation write goes first
  assign in_ready_o  = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------- marker side
  always_comb begin
    ca_n = count_a_q;
    cb_n = count_b_q;
    case (marker_kind_i)
      KIND_A_OPEN:  if (count_a_q != CountMax) ca_n = count_a_q + CountBits'(1);
      KIND_A_CLOSE: if (count_a_q != '0)       ca_n = count_a_q - CountBits'(1);
      KIND_B_OPEN:  if (count_b_q != CountMax) cb_n = count_b_q + CountBits'(1);
      KIND_B_CLOSE: if (count_b_q != '0)       cb_n = count_b_q - CountBits'(1);
      default: ;
    endcase
  end

  assign is_open      = (marker_kind_i == KIND_A_OPEN) || (marker_kind_i == KIND_B_OPEN);
  assign track_second = (set_op_q >= OP_DIFF);
  assign holds_first  = op_holds(set_op_q, |ca_n, |cb_n);
  assign holds_second = op_holds(set_op_q, |cb_n, |ca_n);
  assign addr_next    = marker_address_i + AddrBits'(1);

  // in difference mode the two sides exclude each other, so at most one closes
  assign close_first  = group_end_i && !holds_first && inside_first_q;
  assign close_second = group_end_i && track_second && !holds_second && inside_second_q;
  assign close_lo     = close_first ? start_first_q : start_second_q;
  assign close_hi     = is_open ? (marker_address_i - AddrBits'(1)) : marker_address_i;
  assign close_empty  = (is_open && (marker_address_i == '0)) || (close_lo > close_hi);

  // ---------------------------------------------------------------- shared unit
  assign sum     = lo_q + span_q;
  assign fit     = (sum <= {1'b0, hi_q});
  assign at_end  = (sum == {1'b0, hi_q});
  assign bit_set = lo_q[k_q] || (k_q == KBits'(AddrBits));

  always_comb begin
    state_d         = state_q;
    set_op_d        = set_op_q;
    count_a_d       = count_a_q;
    count_b_d       = count_b_q;
    inside_first_d  = inside_first_q;
    inside_second_d = inside_second_q;
    start_first_d   = start_first_q;
    start_second_d  = start_second_q;
    lo_d            = lo_q;
    hi_d            = hi_q;
    span_d          = span_q;
    k_d             = k_q;
    side_d          = side_q;
    emit            = 1'b0;
    emit_last       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          count_a_d = ca_n;
          count_b_d = cb_n;
          if (group_end_i) begin
            if (holds_first && !inside_first_q && (is_open || marker_address_i != AddrMax)) begin
              inside_first_d = 1'b1;
              start_first_d  = is_open ? marker_address_i : addr_next;
            end
            if (track_second && holds_second && !inside_second_q &&
                (is_open || marker_address_i != AddrMax)) begin
              inside_second_d = 1'b1;
              start_second_d  = is_open ? marker_address_i : addr_next;
            end
            if (close_first)  inside_first_d  = 1'b0;
            if (close_second) inside_second_d = 1'b0;
            if ((close_first || close_second) && !close_empty) begin
              lo_d    = {1'b0, close_lo};
              hi_d    = close_hi;
              side_d  = close_second;
              k_d     = '0;
              span_d  = '0;
              state_d = ST_RISE;
            end
          end
        end
      end
      // grow the block while the cursor stays aligned and the block fits
      ST_RISE: begin
        if (out_free) begin
          if (bit_set) begin
            if (fit) begin
              emit      = 1'b1;
              emit_last = at_end;
              if (at_end) begin
                state_d = ST_IDLE;
              end else begin
                lo_d   = sum + LoBits'(1);
                k_d    = k_q + KBits'(1);
                span_d = {span_q[LoBits-2:0], 1'b1};
              end
            end else begin
              k_d     = k_q - KBits'(1);
              span_d  = span_q >> 1;
              state_d = ST_FALL;
            end
          end else begin
            k_d    = k_q + KBits'(1);
            span_d = {span_q[LoBits-2:0], 1'b1};
          end
        end
      end
      // shrink the block, taking each size that still fits
      ST_FALL: begin
        if (out_free) begin
          if (fit) begin
            emit      = 1'b1;
            emit_last = at_end;
            if (at_end) state_d = ST_IDLE;
            else        lo_d    = sum + LoBits'(1);
          end
          k_d    = k_q - KBits'(1);
          span_d = span_q >> 1;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // a new operation drops any open result range
    if (cfg_fire) begin
      set_op_d        = set_operation_i;
      inside_first_d  = 1'b0;
      inside_second_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      set_op_q        <= OP_UNION;
      count_a_q       <= '0;
      count_b_q       <= '0;
      inside_first_q  <= 1'b0;
      inside_second_q <= 1'b0;
      start_first_q   <= '0;
      start_second_q  <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      set_op_q        <= set_op_d;
      count_a_q       <= count_a_d;
      count_b_q       <= count_b_d;
      inside_first_q  <= inside_first_d;
      inside_second_q <= inside_second_d;
      start_first_q   <= start_first_d;
      start_second_q  <= start_second_d;
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    span_q <= span_d;
    k_q    <= k_d;
    side_q <= side_d;
    if (emit) begin
      out_addr_q <= lo_q[AddrBits-1:0];
      out_len_q  <= LenBits'(AddrBits) - LenBits'(k_q);
      out_side_q <= side_q;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign prefix_address_o = out_addr_q;
  assign prefix_length_o  = out_len_q;
  assign result_side_o    = out_side_q;
  assign last_of_run_o    = out_last_q;

endmodule

### design/isoc_checker.sv
// Port-level checks of the interval set operation block, bound to its top level.
module isoc_checker import isoc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [AddrBits-1:0] prefix_address_o,
  input logic [LenBits-1:0]  prefix_length_o,
  input logic                result_side_o,
  input logic                last_of_run_o,
  input logic                cfg_ready_o
);

  logic [AddrBits-1:0] host_mask;
  assign host_mask = (prefix_length_o == '0) ? {AddrBits{1'b1}}
                                             : ({AddrBits{1'b1}} >> prefix_length_o);

  // stalled request stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out request dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(prefix_address_o) && $stable(prefix_length_o)
      && $stable(result_side_o) && $stable(last_of_run_o))
    else $error("out payload changed under stall");

  // prefix is well formed: length in range, host bits clear
  a_prefix_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (prefix_length_o <= LenBits'(AddrBits))
      && ((prefix_address_o & host_mask) == '0))
    else $error("malformed prefix");

  // more prefixes of the run follow, so no new marker may be taken yet
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> !in_ready_o && !cfg_ready_o)
    else $error("input open while a run is unfinished");

endmodule

bind interval_set_op_to_cidr_top isoc_checker u_isoc_checker (.*);
